// ===== rtl/fcf_pkg.sv =====
package fcf_pkg;

   localparam int SAMPLE_BITS = 16;
   localparam int COEF_BITS = 16;
   localparam int TAP_INDEX_BITS = 9;
   localparam int TAP_COUNT_BITS = 10;
   localparam logic [TAP_COUNT_BITS-1:0] TAP_COUNT_RESET = 10'd26;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_BITS = 2;

   typedef enum logic {
      ITEM_SAMPLE = 1'b0,
      ITEM_TAP = 1'b1
   } fcf_kind_type;

   typedef struct packed {
      fcf_kind_type kind;
      logic [TAP_INDEX_BITS-1:0] tap_index;
      logic signed [SAMPLE_BITS-1:0] value;
   } fcf_item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fcf_queue_status_type;

   typedef struct packed {
      logic busy;
      logic result_load;
   } fcf_back_status_type;

   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_RUN,
      BACK_DRAIN,
      BACK_FINISH
   } fcf_back_state_type;

endpackage

// ===== rtl/fcf_queue.sv =====
module fcf_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  fcf_pkg::fcf_item_type         push_data,
   input  logic                          pop,
   output fcf_pkg::fcf_item_type         pop_data,
   output fcf_pkg::fcf_queue_status_type status
);
   import fcf_pkg::*;

   fcf_item_type entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS:0] wr_ptr_ff;
   logic [QUEUE_PTR_BITS:0] wr_ptr_in;
   logic [QUEUE_PTR_BITS:0] rd_ptr_ff;
   logic [QUEUE_PTR_BITS:0] rd_ptr_in;

   always_comb begin
      status.empty = (wr_ptr_ff == rd_ptr_ff);
      status.full = (wr_ptr_ff[QUEUE_PTR_BITS] != rd_ptr_ff[QUEUE_PTR_BITS]) &&
                    (wr_ptr_ff[QUEUE_PTR_BITS-1:0] == rd_ptr_ff[QUEUE_PTR_BITS-1:0]);
      pop_data = entry_ff[rd_ptr_ff[QUEUE_PTR_BITS-1:0]];
      wr_ptr_in = wr_ptr_ff + ((push && !status.full) ? 1'b1 : 1'b0);
      rd_ptr_in = rd_ptr_ff + ((pop && !status.empty) ? 1'b1 : 1'b0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push && !status.full) begin
         entry_ff[wr_ptr_ff[QUEUE_PTR_BITS-1:0]] <= push_data;
      end
   end

endmodule

// ===== rtl/fcf_front.sv =====
module fcf_front #(
   parameter int MAX_TAPS = 512
) (
   input  logic                                  req_push,
   output logic                                  req_full,
   input  logic                                  req_func,
   input  logic [fcf_pkg::TAP_INDEX_BITS-1:0]    req_tap_index,
   input  logic signed [fcf_pkg::SAMPLE_BITS-1:0] req_value,
   input  fcf_pkg::fcf_queue_status_type         q_status,
   output logic                                  q_push,
   output fcf_pkg::fcf_item_type                 q_data
);
   import fcf_pkg::*;

   logic index_ok;

   // A tap write beyond the store is accepted and dropped here.
   always_comb begin
      index_ok = ({{(32-TAP_INDEX_BITS){1'b0}}, req_tap_index} < 32'(MAX_TAPS));
      req_full = q_status.full;
      q_data.kind = req_func ? ITEM_TAP : ITEM_SAMPLE;
      q_data.tap_index = req_tap_index;
      q_data.value = req_value;
      q_push = req_push && !q_status.full && (!req_func || index_ok);
   end

endmodule

// ===== rtl/fcf_back.sv =====
module fcf_back #(
   parameter int MAX_TAPS = 512
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic [fcf_pkg::TAP_COUNT_BITS-1:0]     tap_count,
   input  fcf_pkg::fcf_item_type                  q_data,
   input  fcf_pkg::fcf_queue_status_type          q_status,
   output logic                                   q_pop,
   output logic                                   rsp_empty,
   input  logic                                   rsp_pop,
   output logic signed [fcf_pkg::SAMPLE_BITS-1:0] rsp_filtered_sample,
   output fcf_pkg::fcf_back_status_type           status
);
   import fcf_pkg::*;

   localparam int AW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
   localparam int CNTW = $clog2(MAX_TAPS + 1);
   localparam int CMPW = (CNTW > TAP_COUNT_BITS) ? CNTW : TAP_COUNT_BITS;
   localparam int PRODW = SAMPLE_BITS + COEF_BITS;
   localparam int ACCW = PRODW + CNTW;
   localparam logic signed [ACCW-1:0] ROUND_HALF = ACCW'(2 ** (COEF_BITS - 2));
   localparam logic signed [ACCW-1:0] SAT_HI = ACCW'(2 ** (SAMPLE_BITS - 1) - 1);
   localparam logic signed [ACCW-1:0] SAT_LO = -SAT_HI - ACCW'(1);

   logic signed [SAMPLE_BITS-1:0] hist_mem [MAX_TAPS];
   logic signed [COEF_BITS-1:0] tap_mem [MAX_TAPS];

   fcf_back_state_type state_ff;
   fcf_back_state_type state_in;
   logic [AW-1:0] newest_ff;
   logic [AW-1:0] newest_in;
   logic [CNTW-1:0] fill_ff;
   logic [CNTW-1:0] fill_in;
   logic [CNTW-1:0] remaining_ff;
   logic [CNTW-1:0] remaining_in;
   logic [AW-1:0] rd_pos_ff;
   logic [AW-1:0] rd_pos_in;
   logic [AW-1:0] k_ff;
   logic [AW-1:0] k_in;
   logic signed [ACCW-1:0] acc_ff;
   logic signed [ACCW-1:0] acc_in;
   logic rd_valid_ff;
   logic prod_valid_ff;
   logic signed [SAMPLE_BITS-1:0] hist_rd_ff;
   logic signed [COEF_BITS-1:0] tap_rd_ff;
   logic signed [PRODW-1:0] prod_ff;
   logic out_valid_ff;
   logic out_valid_in;
   logic signed [SAMPLE_BITS-1:0] out_data_ff;
   logic signed [SAMPLE_BITS-1:0] out_data_in;

   logic issue;
   logic hist_we;
   logic tap_we;
   logic [AW-1:0] new_pos;
   logic [CNTW-1:0] fill_next;
   logic [CNTW-1:0] limit;
   logic [CNTW-1:0] count;
   logic signed [ACCW-1:0] rounded;
   logic signed [ACCW-1:0] shifted;

   always_comb begin
      new_pos = (newest_ff == AW'(MAX_TAPS - 1)) ? '0 : newest_ff + 1'b1;
      fill_next = (fill_ff == CNTW'(MAX_TAPS)) ? fill_ff : fill_ff + 1'b1;
      limit = (CMPW'(tap_count) > CMPW'(MAX_TAPS)) ? CNTW'(MAX_TAPS) : CNTW'(tap_count);
      count = (limit < fill_next) ? limit : fill_next;
      rounded = acc_ff + ROUND_HALF;
      shifted = rounded >>> (COEF_BITS - 1);

      state_in = state_ff;
      newest_in = newest_ff;
      fill_in = fill_ff;
      remaining_in = remaining_ff;
      rd_pos_in = rd_pos_ff;
      k_in = k_ff;
      acc_in = acc_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      out_data_in = out_data_ff;
      q_pop = 1'b0;
      issue = 1'b0;
      hist_we = 1'b0;
      tap_we = 1'b0;
      status.result_load = 1'b0;

      if (prod_valid_ff) begin
         acc_in = acc_ff + {{(ACCW-PRODW){prod_ff[PRODW-1]}}, prod_ff};
      end

      case (state_ff)
         BACK_IDLE: begin
            if (!q_status.empty) begin
               q_pop = 1'b1;
               if (q_data.kind == ITEM_TAP) begin
                  tap_we = 1'b1;
               end else begin
                  hist_we = 1'b1;
                  newest_in = new_pos;
                  fill_in = fill_next;
                  remaining_in = count;
                  rd_pos_in = new_pos;
                  k_in = '0;
                  acc_in = '0;
                  state_in = (count == '0) ? BACK_FINISH : BACK_RUN;
               end
            end
         end
         BACK_RUN: begin
            issue = 1'b1;
            remaining_in = remaining_ff - 1'b1;
            rd_pos_in = (rd_pos_ff == '0) ? AW'(MAX_TAPS - 1) : rd_pos_ff - 1'b1;
            k_in = k_ff + 1'b1;
            if (remaining_ff == CNTW'(1)) begin
               state_in = BACK_DRAIN;
            end
         end
         BACK_DRAIN: begin
            if (!rd_valid_ff && !prod_valid_ff) begin
               state_in = BACK_FINISH;
            end
         end
         BACK_FINISH: begin
            if (!out_valid_ff || rsp_pop) begin
               status.result_load = 1'b1;
               out_valid_in = 1'b1;
               if (shifted > SAT_HI) begin
                  out_data_in = SAT_HI[SAMPLE_BITS-1:0];
               end else if (shifted < SAT_LO) begin
                  out_data_in = SAT_LO[SAMPLE_BITS-1:0];
               end else begin
                  out_data_in = shifted[SAMPLE_BITS-1:0];
               end
               state_in = BACK_IDLE;
            end
         end
         default: begin
            state_in = BACK_IDLE;
         end
      endcase

      status.busy = (state_ff != BACK_IDLE);
      rsp_empty = !out_valid_ff;
      rsp_filtered_sample = out_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BACK_IDLE;
         newest_ff <= '0;
         fill_ff <= '0;
         rd_valid_ff <= 1'b0;
         prod_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         newest_ff <= newest_in;
         fill_ff <= fill_in;
         rd_valid_ff <= issue;
         prod_valid_ff <= rd_valid_ff;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      remaining_ff <= remaining_in;
      rd_pos_ff <= rd_pos_in;
      k_ff <= k_in;
      acc_ff <= acc_in;
      out_data_ff <= out_data_in;
      prod_ff <= PRODW'(hist_rd_ff) * PRODW'(tap_rd_ff);
   end

   always_ff @(posedge clock) begin
      if (hist_we) begin
         hist_mem[new_pos] <= q_data.value;
      end
      if (issue) begin
         hist_rd_ff <= hist_mem[rd_pos_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (tap_we) begin
         tap_mem[AW'(q_data.tap_index)] <= q_data.value;
      end
      if (issue) begin
         tap_rd_ff <= tap_mem[k_ff];
      end
   end

endmodule

// ===== rtl/fir_convolution_filter.sv =====
// Direct-form FIR filter for Q1.15 audio with a programmable impulse response.
// Requests enter through req_push/req_full: req_func low carries a sample in
// req_value, req_func high writes req_value as tap req_tap_index. Results leave
// through rsp_empty/rsp_pop; every sample gives one rsp_filtered_sample, a tap
// write gives none. csr_write_data sets the number of taps in use and is to be
// written while the filter is idle; the block itself does not enforce this.
// Requests wait in a four-entry queue, so req_full rises only when four are
// pending. The datapath takes a tap write from the queue and stores it while
// idle. A sample walks n taps, where n is the smaller of the tap count, capped
// at MAX_TAPS, and the number of samples seen since reset, this one included.
// Once the request is taken, the single multiply-accumulate unit walks one tap
// per cycle through the read, multiply and accumulate registers, and the
// rounding add finishes the result. With no taps in use a sample goes straight
// from the taken request to the rounding add. Reset empties the queue and the
// result register, sets 26 taps and makes the history read as zero; taps must
// be written before they are used. While the result register holds an untaken
// result, the datapath waits before loading the next one and requests keep
// filling the queue.
module fir_convolution_filter #(
   parameter int MAX_TAPS = 512
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_push,
   output logic                                   req_full,
   input  logic                                   req_func,
   input  logic [fcf_pkg::TAP_INDEX_BITS-1:0]     req_tap_index,
   input  logic signed [fcf_pkg::SAMPLE_BITS-1:0] req_value,
   output logic                                   rsp_empty,
   input  logic                                   rsp_pop,
   output logic signed [fcf_pkg::SAMPLE_BITS-1:0] rsp_filtered_sample,
   input  logic                                   csr_write_enable,
   input  logic [fcf_pkg::TAP_COUNT_BITS-1:0]     csr_write_data
);
   import fcf_pkg::*;

   logic [TAP_COUNT_BITS-1:0] tap_count_ff;
   logic [TAP_COUNT_BITS-1:0] tap_count_in;
   logic q_push;
   logic q_pop;
   fcf_item_type q_push_data;
   fcf_item_type q_pop_data;
   fcf_queue_status_type q_status;
   fcf_back_status_type back_status;

   always_comb begin
      tap_count_in = csr_write_enable ? csr_write_data : tap_count_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_count_ff <= TAP_COUNT_RESET;
      end else begin
         tap_count_ff <= tap_count_in;
      end
   end

   fcf_front #(.MAX_TAPS(MAX_TAPS)) u_front (
      .req_push      (req_push),
      .req_full      (req_full),
      .req_func      (req_func),
      .req_tap_index (req_tap_index),
      .req_value     (req_value),
      .q_status      (q_status),
      .q_push        (q_push),
      .q_data        (q_push_data)
   );

   fcf_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .status    (q_status)
   );

   fcf_back #(.MAX_TAPS(MAX_TAPS)) u_back (
      .clock               (clock),
      .reset               (reset),
      .tap_count           (tap_count_ff),
      .q_data              (q_pop_data),
      .q_status            (q_status),
      .q_pop               (q_pop),
      .rsp_empty           (rsp_empty),
      .rsp_pop             (rsp_pop),
      .rsp_filtered_sample (rsp_filtered_sample),
      .status              (back_status)
   );

   a_pop_not_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_status.empty)
      else $error("datapath took a request from an empty queue");

   a_pop_only_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !back_status.busy)
      else $error("datapath took a request while busy");

   a_result_taken: assert property (@(posedge clock) disable iff (reset)
      (rsp_pop && !rsp_empty && !back_status.result_load) |=> rsp_empty)
      else $error("result stayed after it was taken");

   a_load_free_slot: assert property (@(posedge clock) disable iff (reset)
      back_status.result_load |-> (rsp_empty || rsp_pop))
      else $error("result overwritten before it was taken");

endmodule
